// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the availability tracker checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PMAT_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pmat assertion failed");

// consequent must hold in the cycle after the antecedent
`define PMAT_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pmat assertion failed");

`endif

// ===== rtl/core/pmat_pkg.sv =====
// ----------------------------------------------------------------------------
// pmat_pkg
// field widths, command and status codes shared by the availability tracker
// ----------------------------------------------------------------------------
package pmat_pkg;

  // transaction field widths
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 16;
  localparam int RATE_IN_W  = 48;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = 17;
  localparam int PCT_W      = 14;
  localparam int THR_W      = 32;
  localparam int WIN_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_STORED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REPORT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 1'b1;

  // reset values and limits
  localparam logic [THR_W-1:0] THR_RESET = 32'd10;
  localparam logic [CNT_W-1:0] CNT_MAX   = 17'h1FFFF;
  localparam logic [PCT_W-1:0] PCT_FULL  = 14'd10000;

endpackage

// ===== rtl/core/pmat_if.sv =====
// ----------------------------------------------------------------------------
// pmat_if
// valid/ready channels for command and result transactions
// ----------------------------------------------------------------------------

// command channel
interface pmat_in_if;
  import pmat_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [IDX_W-1:0]     minute_index;
  logic [RATE_IN_W-1:0] upload_rate;
  logic [RATE_IN_W-1:0] download_rate;

  modport source (output valid, cmd, minute_index, upload_rate, download_rate,
                  input ready);
  modport sink (input valid, cmd, minute_index, upload_rate, download_rate,
                output ready);
endinterface

// result channel
interface pmat_out_if;
  import pmat_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    measured_count;
  logic [CNT_W-1:0]    available_count;
  logic [PCT_W-1:0]    measured_pct;
  logic [PCT_W-1:0]    available_pct;
  logic [PCT_W-1:0]    max_possible_pct;

  modport source (output valid, status, measured_count, available_count,
                  measured_pct, available_pct, max_possible_pct,
                  input ready);
  modport sink (input valid, status, measured_count, available_count,
                measured_pct, available_pct, max_possible_pct,
                output ready);
endinterface

// ===== rtl/core/pmat_ram.sv =====
// ----------------------------------------------------------------------------
// pmat_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pmat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/per_minute_availability_tracker.sv =====
// Sample: read of the bin, then modify and write back, one sample at a time.
// Report: three shares in turn, each set directly or by a 14-step division on one shared divider.
// Clear: one bin zeroed per cycle through the single write port.
// Reset: synchronous, active low; a clearing pass over all MAX_MINUTES bins follows reset,
// during which no command is accepted (configuration writes are taken as ever).
// ----------------------------------------------------------------------------
// per_minute_availability_tracker
// per-minute bin table with peak rates and running availability totals
// ----------------------------------------------------------------------------
module per_minute_availability_tracker #(
  parameter int MAX_MINUTES = 65536,
  parameter int RATE_WIDTH  = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pmat_in_if.sink                         in_ch,
  pmat_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [pmat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmat_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pmat_pkg::*;

  localparam int ADDR_W  = (MAX_MINUTES > 1) ? $clog2(MAX_MINUTES) : 1;
  localparam int ENTRY_W = 2 + 2 * RATE_WIDTH;
  localparam int NUM_W   = WIN_W + PCT_W;
  localparam int DSR_W   = NUM_W - 1;
  localparam int STEP_W  = $clog2(PCT_W);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_MINUTES - 1);
  localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(PCT_W - 1);
  localparam logic [1:0]        SEL_LAST  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_UPDATE, S_LOAD, S_DIVIDE, S_EMIT
  } state_t;

  typedef struct packed {
    logic                  measured;
    logic                  counted;
    logic [RATE_WIDTH-1:0] peak_up;
    logic [RATE_WIDTH-1:0] peak_down;
  } entry_t;

  // control and working registers
  state_t                state_r;
  logic [THR_W-1:0]      thr_r;
  logic [WIN_W-1:0]      window_r;
  logic [CNT_W-1:0]      meas_total_r;
  logic [CNT_W-1:0]      avail_total_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [RATE_WIDTH-1:0] up_r;
  logic [RATE_WIDTH-1:0] down_r;
  logic [ADDR_W-1:0]     clr_addr_r;
  logic                  clr_reply_r;
  logic [STATUS_W-1:0]   emit_status_r;
  logic [1:0]            sel_r;
  logic [STEP_W-1:0]     step_r;
  logic [NUM_W-1:0]      rem_r;
  logic [DSR_W-1:0]      dsr_r;
  logic [PCT_W-1:0]      quo_r;
  logic [PCT_W-1:0]      pct_r [3];

  // output register
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [CNT_W-1:0]      out_meas_r;
  logic [CNT_W-1:0]      out_avail_r;
  logic [PCT_W-1:0]      out_pmeas_r;
  logic [PCT_W-1:0]      out_pavail_r;
  logic [PCT_W-1:0]      out_pmax_r;

  // ram ports
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;

  // combinational helpers
  logic                  out_free;
  logic                  out_load;
  logic                  accept;
  logic [WIN_W-1:0]      win_eff;
  logic                  in_range;
  entry_t                rd_entry;
  entry_t                new_entry;
  logic [RATE_WIDTH-1:0] new_up;
  logic [RATE_WIDTH-1:0] new_down;
  logic                  hit;
  logic                  meas_inc;
  logic                  avail_inc;
  logic [WIN_W-1:0]      unmeas;
  logic [CNT_W:0]        max_cnt;
  logic [CNT_W:0]        div_cnt;
  logic [NUM_W-1:0]      div_num;
  logic                  ge;
  logic [NUM_W-1:0]      rem_sub;
  logic                  sel_last;

  // handshake
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_load     = ((state_r == S_UPDATE) || (state_r == S_EMIT)) && out_free;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;

  // effective window, capped at the table depth
  assign win_eff  = (32'(window_r) > 32'(MAX_MINUTES)) ? WIN_W'(MAX_MINUTES) : window_r;
  assign in_range = ({1'b0, in_ch.minute_index} < win_eff);

  // bin update: raise peaks, mark measured, count once when a peak reaches threshold
  always_comb begin
    rd_entry  = entry_t'(ram_rdata);
    new_up    = (up_r > rd_entry.peak_up) ? up_r : rd_entry.peak_up;
    new_down  = (down_r > rd_entry.peak_down) ? down_r : rd_entry.peak_down;
    hit       = (64'(new_up) >= 64'(thr_r)) || (64'(new_down) >= 64'(thr_r));
    new_entry.measured  = 1'b1;
    new_entry.counted   = rd_entry.counted || hit;
    new_entry.peak_up   = new_up;
    new_entry.peak_down = new_down;
    meas_inc  = !rd_entry.measured && (meas_total_r != CNT_MAX);
    avail_inc = !rd_entry.counted && hit && (avail_total_r != CNT_MAX);
  end

  // report operands
  always_comb begin
    unmeas  = (win_eff > meas_total_r) ? (win_eff - meas_total_r) : '0;
    max_cnt = {1'b0, avail_total_r} + {1'b0, unmeas};
    case (sel_r)
      2'd0:    div_cnt = {1'b0, meas_total_r};
      2'd1:    div_cnt = {1'b0, avail_total_r};
      default: div_cnt = max_cnt;
    endcase
    div_num  = NUM_W'(div_cnt[WIN_W-1:0]) * NUM_W'(PCT_FULL);
    ge       = (rem_r >= {1'b0, dsr_r});
    rem_sub  = rem_r - {1'b0, dsr_r};
    sel_last = (sel_r == SEL_LAST);
  end

  // ram write side: clearing sweep or read-modify-write of one bin
  always_comb begin
    ram_we    = (state_r == S_CLEAR) || ((state_r == S_UPDATE) && out_free);
    ram_waddr = (state_r == S_CLEAR) ? clr_addr_r : addr_r;
    ram_wdata = (state_r == S_CLEAR) ? '0 : ENTRY_W'(new_entry);
  end

  pmat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_MINUTES)
  ) u_pmat_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ADDR_W'(in_ch.minute_index)),
    .rdata (ram_rdata)
  );

  // sequencer, totals, divider and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      thr_r         <= THR_RESET;
      window_r      <= '0;
      meas_total_r  <= '0;
      avail_total_r <= '0;
      clr_addr_r    <= '0;
      clr_reply_r   <= 1'b0;
      sel_r         <= '0;
      step_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: thr_r    <= cfg_wdata[THR_W-1:0];
          REG_WINDOW:    window_r <= cfg_wdata[WIN_W-1:0];
          default:       ;
        endcase
      end

      // result valid: set on a new result, dropped once taken downstream
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        // zero one bin per cycle, then the totals
        S_CLEAR: begin
          if (clr_addr_r == LAST_ADDR) begin
            clr_addr_r    <= '0;
            meas_total_r  <= '0;
            avail_total_r <= '0;
            if (clr_reply_r) begin
              emit_status_r <= ST_CLEARED;
              state_r       <= S_EMIT;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            clr_addr_r <= clr_addr_r + 1'b1;
          end
        end

        // take a command; the bin read is issued on the same edge
        S_IDLE: begin
          if (accept) begin
            case (in_ch.cmd)
              CMD_SAMPLE: begin
                addr_r <= ADDR_W'(in_ch.minute_index);
                up_r   <= RATE_WIDTH'(in_ch.upload_rate);
                down_r <= RATE_WIDTH'(in_ch.download_rate);
                if (in_range) begin
                  state_r <= S_UPDATE;
                end else begin
                  emit_status_r <= ST_IGNORED;
                  state_r       <= S_EMIT;
                end
              end
              CMD_REPORT: begin
                sel_r   <= '0;
                state_r <= S_LOAD;
              end
              CMD_CLEAR: begin
                clr_reply_r <= 1'b1;
                state_r     <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end

        // write the bin back and reply once the output slot is free
        S_UPDATE: begin
          if (out_free) begin
            meas_total_r  <= meas_total_r + CNT_W'(meas_inc);
            avail_total_r <= avail_total_r + CNT_W'(avail_inc);
            out_status_r  <= ST_STORED;
            out_meas_r    <= meas_total_r + CNT_W'(meas_inc);
            out_avail_r   <= avail_total_r + CNT_W'(avail_inc);
            out_pmeas_r   <= '0;
            out_pavail_r  <= '0;
            out_pmax_r    <= '0;
            state_r       <= S_IDLE;
          end
        end

        // set up one share: zero window, saturation, or a long division
        S_LOAD: begin
          if ((win_eff == '0) || (div_cnt >= {1'b0, win_eff})) begin
            pct_r[sel_r] <= (win_eff == '0) ? '0 : PCT_FULL;
            if (sel_last) begin
              emit_status_r <= ST_REPORT;
              state_r       <= S_EMIT;
            end else begin
              sel_r <= sel_r + 1'b1;
            end
          end else begin
            rem_r   <= div_num;
            dsr_r   <= {win_eff, {(PCT_W-1){1'b0}}};
            quo_r   <= '0;
            step_r  <= FIRST_STEP;
            state_r <= S_DIVIDE;
          end
        end

        // restoring division, one quotient bit per cycle
        S_DIVIDE: begin
          quo_r  <= {quo_r[PCT_W-2:0], ge};
          dsr_r  <= dsr_r >> 1;
          step_r <= step_r - 1'b1;
          if (ge) begin
            rem_r <= rem_sub;
          end
          if (step_r == '0) begin
            pct_r[sel_r] <= {quo_r[PCT_W-2:0], ge};
            if (sel_last) begin
              emit_status_r <= ST_REPORT;
              state_r       <= S_EMIT;
            end else begin
              sel_r   <= sel_r + 1'b1;
              state_r <= S_LOAD;
            end
          end
        end

        // load the output register
        S_EMIT: begin
          if (out_free) begin
            out_status_r <= emit_status_r;
            out_meas_r   <= meas_total_r;
            out_avail_r  <= avail_total_r;
            out_pmeas_r  <= (emit_status_r == ST_REPORT) ? pct_r[0] : '0;
            out_pavail_r <= (emit_status_r == ST_REPORT) ? pct_r[1] : '0;
            out_pmax_r   <= (emit_status_r == ST_REPORT) ? pct_r[2] : '0;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result channel
  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.measured_count   = out_meas_r;
  assign out_ch.available_count  = out_avail_r;
  assign out_ch.measured_pct     = out_pmeas_r;
  assign out_ch.available_pct    = out_pavail_r;
  assign out_ch.max_possible_pct = out_pmax_r;

endmodule

// ===== rtl/core/pmat_checker.sv =====
// ----------------------------------------------------------------------------
// pmat_checker
// port-level checks on the result channel of the availability tracker
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmat_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pmat_pkg::STATUS_W-1:0]  out_status,
  input logic [pmat_pkg::CNT_W-1:0]     out_measured_count,
  input logic [pmat_pkg::CNT_W-1:0]     out_available_count,
  input logic [pmat_pkg::PCT_W-1:0]     out_measured_pct,
  input logic [pmat_pkg::PCT_W-1:0]     out_available_pct,
  input logic [pmat_pkg::PCT_W-1:0]     out_max_possible_pct
);
  import pmat_pkg::*;

  // a stalled result stays offered with the same status
  `PMAT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status))

  // shares appear only in a report
  `PMAT_ASSERT_NOW(a_pct_zero, clk, rst_n, out_valid && (out_status != ST_REPORT), (out_measured_pct == '0) && (out_available_pct == '0) && (out_max_possible_pct == '0))

  // an available minute is always a measured one
  `PMAT_ASSERT_NOW(a_avail_le_meas, clk, rst_n, out_valid, out_available_count <= out_measured_count)

  // a clear leaves both totals at zero
  `PMAT_ASSERT_NOW(a_clear_zero, clk, rst_n, out_valid && (out_status == ST_CLEARED), (out_measured_count == '0) && (out_available_count == '0))

  // shares are bounded and the best case is never below the available share
  `PMAT_ASSERT_NOW(a_report_bounds, clk, rst_n, out_valid && (out_status == ST_REPORT), (out_measured_pct <= PCT_FULL) && (out_max_possible_pct <= PCT_FULL) && (out_max_possible_pct >= out_available_pct))

endmodule

bind per_minute_availability_tracker pmat_checker u_pmat_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_status           (out_ch.status),
  .out_measured_count   (out_ch.measured_count),
  .out_available_count  (out_ch.available_count),
  .out_measured_pct     (out_ch.measured_pct),
  .out_available_pct    (out_ch.available_pct),
  .out_max_possible_pct (out_ch.max_possible_pct)
);
